### rtl/core/gpiop_pkg.sv
// Shared types, register offsets and pin mask for the GPIO port with interrupts.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package gpiop_pkg;

  localparam int unsigned PIN_COUNT = 32;
  localparam logic [31:0] PIN_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  localparam logic [6:0] OFS_DATA   = 7'h00;
  localparam logic [6:0] OFS_DIR    = 7'h04;
  localparam logic [6:0] OFS_INTEN  = 7'h30;
  localparam logic [6:0] OFS_TYPE   = 7'h38;
  localparam logic [6:0] OFS_POL    = 7'h3c;
  localparam logic [6:0] OFS_STATUS = 7'h40;
  localparam logic [6:0] OFS_EOI    = 7'h4c;
  localparam logic [6:0] OFS_EXT    = 7'h50;

  typedef struct packed {
    logic [1:0]  func;
    logic [6:0]  offset;
    logic [31:0] wdata;
    logic [31:0] pins;
  } cmd_t;

  typedef struct packed {
    logic [31:0] out_data;
    logic [31:0] direction;
    logic [31:0] irq_enable;
    logic [31:0] irq_type;
    logic [31:0] irq_polarity;
  } cfg_t;

  typedef struct packed {
    logic [31:0] status;
    logic [31:0] last_pins;
  } irq_view_t;

endpackage

`default_nettype wire

### rtl/core/gpiop_regs.sv
// Software-visible control registers: output data, direction and interrupt setup.
// Depends on gpiop_pkg for the command and register structs and offsets.
`default_nettype none

module gpiop_regs
  import gpiop_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic upd_i,
  input  wire cmd_t cmd_i,
  output cfg_t      cfg_q_o,
  output cfg_t      cfg_d_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic [31:0] wdata_m;

  assign wdata_m = cmd_i.wdata & PIN_MASK;

  always_comb begin
    cfg_d = cfg_q;
    if (upd_i && (cmd_i.func == FUNC_WRITE)) begin
      case (cmd_i.offset)
        OFS_DATA:  cfg_d.out_data     = wdata_m;
        OFS_DIR:   cfg_d.direction    = wdata_m;
        OFS_INTEN: cfg_d.irq_enable   = wdata_m;
        OFS_TYPE:  cfg_d.irq_type     = wdata_m;
        OFS_POL:   cfg_d.irq_polarity = wdata_m;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_q_o = cfg_q;
  assign cfg_d_o = cfg_d;

endmodule

`default_nettype wire

### rtl/core/gpiop_irq.sv
// Interrupt unit: last pin sample, latched edges and the per-pin status word.
// Depends on gpiop_pkg and on the control register values from gpiop_regs.
`default_nettype none

module gpiop_irq
  import gpiop_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      upd_i,
  input  wire cmd_t      cmd_i,
  input  wire cfg_t      cfg_q_i,
  input  wire cfg_t      cfg_d_i,
  output irq_view_t      view_o
);

  logic [31:0] edge_latched_q, edge_latched_d;
  logic [31:0] last_pins_q, last_pins_d;
  logic [31:0] pins_m;
  logic [31:0] rising, falling, events;

  assign pins_m  = cmd_i.pins & PIN_MASK;
  assign rising  = pins_m & ~last_pins_q;
  assign falling = last_pins_q & ~pins_m;
  assign events  = (cfg_q_i.irq_polarity & rising) | (~cfg_q_i.irq_polarity & falling);

  always_comb begin
    edge_latched_d = edge_latched_q;
    last_pins_d    = last_pins_q;
    if (upd_i && (cmd_i.func == FUNC_TICK)) begin
      edge_latched_d = edge_latched_q
                     | (events & cfg_q_i.irq_type & cfg_q_i.irq_enable & PIN_MASK);
      last_pins_d    = pins_m;
    end else if (upd_i && (cmd_i.func == FUNC_WRITE) && (cmd_i.offset == OFS_EOI)) begin
      edge_latched_d = edge_latched_q & ~(cmd_i.wdata & PIN_MASK);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_latched_q <= '0;
      last_pins_q    <= '0;
    end else begin
      edge_latched_q <= edge_latched_d;
      last_pins_q    <= last_pins_d;
    end
  end

  // The status reflects the state as it stands after the current command.
  assign view_o.status = cfg_d_i.irq_enable
                       & ((~cfg_d_i.irq_type & ~(last_pins_d ^ cfg_d_i.irq_polarity))
                          | (cfg_d_i.irq_type & edge_latched_d))
                       & PIN_MASK;
  assign view_o.last_pins = last_pins_q;

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(edge_latched_q) && $stable(last_pins_q))
    else $error("interrupt state changed without a command");

  a_tick_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && (cmd_i.func == FUNC_TICK)
      |=> (edge_latched_q & $past(edge_latched_q)) == $past(edge_latched_q))
    else $error("pin sample cleared a latched edge");

  a_tick_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && (cmd_i.func == FUNC_TICK) |=> last_pins_q == ($past(cmd_i.pins) & PIN_MASK))
    else $error("pin sample not recorded");

  a_eoi_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && (cmd_i.func == FUNC_WRITE) && (cmd_i.offset == OFS_EOI)
      |=> (edge_latched_q & $past(cmd_i.wdata)) == '0)
    else $error("end of interrupt write left a latched edge set");

endmodule

`default_nettype wire

### rtl/core/gpio_port_with_interrupts.sv
// Top level of the 32-pin GPIO port with interrupts: input register, read decode, result register.
// Depends on gpiop_pkg, gpiop_regs and gpiop_irq.
`default_nettype none

// Each input beat is a bus read, a bus write or a pin sample tick, and each produces exactly
// one result beat carrying the read data (zero unless a read), the driven pin values, the
// output enables and the interrupt line, all as they stand after that beat. The block takes
// one beat per clock cycle; a beat is held in the input register, where the register update and
// read decode happen, until the result register can take it, and its result then appears in
// the result register. Only a stalled result register slows acceptance.
module gpio_port_with_interrupts
  import gpiop_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [6:0]  reg_offset_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [31:0] pin_levels_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_data_o,
  output logic [31:0]      pin_out_values_o,
  output logic [31:0]      pin_out_enables_o,
  output logic             irq_line_o
);

  logic        s1_valid_q;
  cmd_t        s1_cmd_q;
  logic        out_valid_q;
  logic [31:0] read_data_q, pin_out_values_q, pin_out_enables_q;
  logic        irq_line_q;
  logic        adv;
  logic        in_acc;
  cfg_t        cfg_q, cfg_d;
  irq_view_t   view;
  logic [31:0] rdata;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  gpiop_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (adv),
    .cmd_i   (s1_cmd_q),
    .cfg_q_o (cfg_q),
    .cfg_d_o (cfg_d)
  );

  gpiop_irq u_irq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (adv),
    .cmd_i   (s1_cmd_q),
    .cfg_q_i (cfg_q),
    .cfg_d_i (cfg_d),
    .view_o  (view)
  );

  always_comb begin
    rdata = '0;
    if (s1_cmd_q.func == FUNC_READ) begin
      case (s1_cmd_q.offset)
        OFS_DATA:   rdata = cfg_q.out_data;
        OFS_DIR:    rdata = cfg_q.direction;
        OFS_INTEN:  rdata = cfg_q.irq_enable;
        OFS_TYPE:   rdata = cfg_q.irq_type;
        OFS_POL:    rdata = cfg_q.irq_polarity;
        OFS_STATUS: rdata = view.status;
        OFS_EXT:    rdata = view.last_pins;
        default:    rdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q.func   <= func_i;
      s1_cmd_q.offset <= reg_offset_i;
      s1_cmd_q.wdata  <= write_data_i;
      s1_cmd_q.pins   <= pin_levels_i;
    end
    if (adv) begin
      read_data_q       <= rdata;
      pin_out_values_q  <= cfg_d.out_data;
      pin_out_enables_q <= cfg_d.direction;
      irq_line_q        <= |view.status;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = read_data_q;
  assign pin_out_values_o  = pin_out_values_q;
  assign pin_out_enables_o = pin_out_enables_q;
  assign irq_line_o        = irq_line_q;

endmodule

`default_nettype wire

### bench/gpiop_port_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the GPIO port, keeps its own copy of the port registers,
// and compares every result beat with the one predicted. Depends on gpiop_pkg.
module gpiop_port_checker
  import gpiop_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [6:0]  reg_offset_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] pin_levels_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] read_data_i,
  input  logic [31:0] pin_out_values_i,
  input  logic [31:0] pin_out_enables_i,
  input  logic        irq_line_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] pin_values;
    logic [31:0] pin_enables;
    logic        irq;
  } port_view_t;

  port_view_t  pending_port_views[$];
  logic [31:0] out_data_q;
  logic [31:0] dir_q;
  logic [31:0] inten_q;
  logic [31:0] edge_type_q;
  logic [31:0] polarity_q;
  logic [31:0] latched_q;
  logic [31:0] pins_q;

  function automatic logic [31:0] irq_status_bits();
    logic [31:0] level_hits;
    logic [31:0] edge_hits;
    level_hits = ~edge_type_q & ~(pins_q ^ polarity_q);
    edge_hits  = edge_type_q & latched_q;
    return inten_q & (level_hits | edge_hits) & PIN_MASK;
  endfunction

  function automatic logic [31:0] register_value(input logic [6:0] ofs);
    case (ofs)
      OFS_DATA:   return out_data_q;
      OFS_DIR:    return dir_q;
      OFS_INTEN:  return inten_q;
      OFS_TYPE:   return edge_type_q;
      OFS_POL:    return polarity_q;
      OFS_STATUS: return irq_status_bits();
      OFS_EXT:    return pins_q;
      default:    return 32'd0;
    endcase
  endfunction

  task automatic track_port_state(input logic [1:0] func, input logic [6:0] ofs,
                                  input logic [31:0] wdata, input logic [31:0] pins);
    port_view_t  view;
    logic [31:0] data;
    logic [31:0] sample;
    logic [31:0] rising;
    logic [31:0] falling;
    logic [31:0] events;
    view.read_data = 32'd0;
    data   = wdata & PIN_MASK;
    sample = pins & PIN_MASK;
    case (func)
      FUNC_READ: begin
        view.read_data = register_value(ofs);
      end
      FUNC_WRITE: begin
        case (ofs)
          OFS_DATA:  out_data_q = data;
          OFS_DIR:   dir_q = data;
          OFS_INTEN: inten_q = data;
          OFS_TYPE:  edge_type_q = data;
          OFS_POL:   polarity_q = data;
          OFS_EOI:   latched_q = latched_q & ~data;
          default:   ;
        endcase
      end
      FUNC_TICK: begin
        rising    = sample & ~pins_q;
        falling   = pins_q & ~sample;
        events    = (polarity_q & rising) | (~polarity_q & falling);
        latched_q = latched_q | (events & edge_type_q & inten_q & PIN_MASK);
        pins_q    = sample;
      end
      default: ;
    endcase
    view.pin_values  = out_data_q;
    view.pin_enables = dir_q;
    view.irq         = (irq_status_bits() != 32'd0);
    pending_port_views.push_back(view);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h, expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_result_beat();
    port_view_t want;
    if (pending_port_views.size() == 0) begin
      report_mismatch("result beat with none expected, read_data", read_data_i, 32'd0);
    end else begin
      want = pending_port_views.pop_front();
      if (read_data_i !== want.read_data)
        report_mismatch("read_data", read_data_i, want.read_data);
      if (pin_out_values_i !== want.pin_values)
        report_mismatch("pin_out_values", pin_out_values_i, want.pin_values);
      if (pin_out_enables_i !== want.pin_enables)
        report_mismatch("pin_out_enables", pin_out_enables_i, want.pin_enables);
      if (irq_line_i !== want.irq)
        report_mismatch("irq_line", {31'd0, irq_line_i}, {31'd0, want.irq});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q    = '0;
      dir_q         = '0;
      inten_q       = '0;
      edge_type_q   = '0;
      polarity_q    = '0;
      latched_q     = '0;
      pins_q        = '0;
      fail_count_o  = 0;
      outstanding_o = 0;
      pending_port_views.delete();
    end else begin
      if (out_valid_i && out_ready_i)
        check_result_beat();
      if (in_valid_i && in_ready_i)
        track_port_state(func_i, reg_offset_i, write_data_i, pin_levels_i);
      outstanding_o = pending_port_views.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the GPIO port bench: clock, reset, directed and random bus and pin beats, random
// stalls on the result side, the verdict. Needs gpiop_pkg, gpiop_port_checker and the DUT.
module tb_top;
  import gpiop_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int PHASES = 16;
  localparam int BEATS_PER_PHASE = 100;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_READ;
  logic [6:0]  reg_offset_i = OFS_DATA;
  logic [31:0] write_data_i = '0;
  logic [31:0] pin_levels_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_data_o;
  logic [31:0] pin_out_values_o;
  logic [31:0] pin_out_enables_o;
  logic        irq_line_o;
  int          fail_count;
  int          outstanding;
  logic        hold_off_req = 1'b0;
  logic [31:0] pins_now = '0;
  logic [6:0]  known_ofs [8] = '{OFS_DATA, OFS_DIR, OFS_INTEN, OFS_TYPE,
                                 OFS_POL, OFS_STATUS, OFS_EOI, OFS_EXT};

  always #5 clk_i = ~clk_i;

  gpio_port_with_interrupts i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .reg_offset_i      (reg_offset_i),
    .write_data_i      (write_data_i),
    .pin_levels_i      (pin_levels_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .pin_out_values_o  (pin_out_values_o),
    .pin_out_enables_o (pin_out_enables_o),
    .irq_line_o        (irq_line_o)
  );

  gpiop_port_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .func_i            (func_i),
    .reg_offset_i      (reg_offset_i),
    .write_data_i      (write_data_i),
    .pin_levels_i      (pin_levels_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_i       (read_data_o),
    .pin_out_values_i  (pin_out_values_o),
    .pin_out_enables_i (pin_out_enables_o),
    .irq_line_i        (irq_line_o),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hffff_ffff;
    return $urandom;
  endfunction

  task automatic send_beat(input logic [1:0] func, input logic [6:0] ofs,
                           input logic [31:0] wdata, input logic [31:0] pins, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    func_i       <= func;
    reg_offset_i <= ofs;
    write_data_i <= wdata;
    pin_levels_i <= pins;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random_beat(input int gap);
    logic [1:0]  func;
    logic [6:0]  ofs;
    logic [31:0] pins;
    int          r;
    r    = $urandom_range(0, 99);
    ofs  = known_ofs[$urandom_range(0, 7)];
    case ($urandom_range(0, 4))
      0:       pins = $urandom;
      1:       pins = $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
      2:       pins = pins_now ^ ($urandom & $urandom & $urandom);
      default: pins = pins_now ^ (32'd1 << $urandom_range(0, 31))
                               ^ (32'd1 << $urandom_range(0, 31));
    endcase
    if (r < 35) begin
      func = FUNC_TICK;
    end else if (r < 60) begin
      func = FUNC_WRITE;
    end else if (r < 85) begin
      func = FUNC_READ;
    end else begin
      func = 2'($urandom_range(0, 3));
      ofs  = 7'($urandom_range(0, 127));
    end
    if (func == FUNC_TICK)
      pins_now = pins;
    send_beat(func, ofs, random_word(), pins, gap);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0)
      @(negedge clk_i);
  endtask

  initial begin
    int stall_left;
    int run_left;
    int r;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ready_i <= 1'b1;
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) run_left = $urandom_range(50, 150);
        else if (r < 14) stall_left = $urandom_range(20, 60);
        else if (r < 50) stall_left = $urandom_range(1, 3);
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_beat(FUNC_WRITE, OFS_DATA, 32'hffff_ffff, 32'd0, pick_gap());
    send_beat(FUNC_WRITE, OFS_DIR, 32'ha5a5_a5a5, 32'd0, pick_gap());
    send_beat(FUNC_READ, OFS_DATA, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_READ, OFS_DIR, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_WRITE, OFS_DATA, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_TICK, OFS_DATA, 32'd0, 32'hffff_ffff, pick_gap());
    send_beat(FUNC_READ, OFS_EXT, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_WRITE, OFS_INTEN, 32'hffff_ffff, 32'd0, pick_gap());
    send_beat(FUNC_READ, OFS_STATUS, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_WRITE, OFS_POL, 32'hffff_ffff, 32'd0, pick_gap());
    send_beat(FUNC_READ, OFS_STATUS, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_WRITE, OFS_TYPE, 32'hffff_0000, 32'd0, pick_gap());
    send_beat(FUNC_TICK, OFS_DATA, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_TICK, OFS_DATA, 32'd0, 32'hffff_ffff, pick_gap());
    send_beat(FUNC_READ, OFS_STATUS, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_WRITE, OFS_EOI, 32'hffff_ffff, 32'd0, pick_gap());
    send_beat(FUNC_READ, OFS_EOI, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_WRITE, OFS_STATUS, 32'h0000_1234, 32'd0, pick_gap());
    send_beat(FUNC_WRITE, OFS_EXT, 32'h0000_5678, 32'd0, pick_gap());
    send_beat(FUNC_READ, 7'h02, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_WRITE, 7'h7f, 32'hffff_ffff, 32'd0, pick_gap());
    send_beat(FUNC_READ, 7'h7f, 32'd0, 32'd0, pick_gap());
    send_beat(FUNC_UNUSED, OFS_DATA, 32'hffff_ffff, 32'hffff_ffff, pick_gap());
    send_beat(FUNC_WRITE, OFS_INTEN, 32'd0, 32'd0, pick_gap());
    pins_now = 32'hffff_ffff;
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        @(posedge clk_i);
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++)
        send_random_beat((ph % 4 == 1 || ph == 3) ? 0 : pick_gap());
      if (ph % 2 == 0)
        drain_results();
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
